### sv/ftpg_pkg.sv
`default_nettype none
package ftpg_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

  // CORDIC datapath width: covers pre-rotation plus gain growth and the
  // accumulated angle past +-pi
  localparam int CW = 34;

  localparam logic signed [CW-1:0] ANG_QUARTER = 34'sd1073741824;
  localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;

  localparam logic [2:0] REG_FOLLOW_ENABLE    = 3'd0;
  localparam logic [2:0] REG_DESIRED_DISTANCE = 3'd1;
  localparam logic [2:0] REG_OFFSET_FLOOR     = 3'd2;
  localparam logic [2:0] REG_OFFSET_CEILING   = 3'd3;
  localparam logic [2:0] REG_DISTANCE_GAIN    = 3'd4;
  localparam logic [2:0] REG_MIN_INTERVAL     = 3'd5;

  typedef logic signed [CW-1:0] cval_t;

  typedef struct packed {
    logic start;
    logic vec_mode;
  } cordic_ctl_t;

  // atan(2^-i) with 2^31 = pi
  function automatic cval_t atan_entry(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return cval_t'({2'b00, v});
  endfunction

endpackage
`default_nettype wire

### sv/ftpg_cordic.sv
`default_nettype none
module ftpg_cordic (
  input  wire                  clk,
  input  wire                  rst_n,
  input  ftpg_pkg::cordic_ctl_t ctl,
  input  ftpg_pkg::cval_t      x_in,
  input  ftpg_pkg::cval_t      y_in,
  input  ftpg_pkg::cval_t      z_in,
  output logic                 busy,
  output logic                 done,
  output ftpg_pkg::cval_t      x_out,
  output ftpg_pkg::cval_t      y_out,
  output ftpg_pkg::cval_t      z_out
);

  ftpg_pkg::cval_t x_r, y_r, z_r;
  ftpg_pkg::cval_t x_nxt, y_nxt, z_nxt;
  ftpg_pkg::cval_t x_ld, y_ld, z_ld;
  ftpg_pkg::cval_t sx, sy, at;
  logic [ftpg_pkg::STEP_W-1:0] cnt_r;
  logic busy_r, done_r, mode_r, cw;

  // quadrant pre-rotation on load
  always_comb begin
    if (ctl.vec_mode) begin
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_ld = y_in;
          y_ld = -x_in;
          z_ld = ftpg_pkg::ANG_QUARTER;
        end else begin
          x_ld = -y_in;
          y_ld = x_in;
          z_ld = -ftpg_pkg::ANG_QUARTER;
        end
      end else begin
        x_ld = x_in;
        y_ld = y_in;
        z_ld = '0;
      end
    end else begin
      if (z_in > ftpg_pkg::ANG_QUARTER) begin
        x_ld = '0;
        y_ld = ftpg_pkg::CORDIC_K;
        z_ld = z_in - ftpg_pkg::ANG_QUARTER;
      end else if (z_in < -ftpg_pkg::ANG_QUARTER) begin
        x_ld = '0;
        y_ld = -ftpg_pkg::CORDIC_K;
        z_ld = z_in + ftpg_pkg::ANG_QUARTER;
      end else begin
        x_ld = ftpg_pkg::CORDIC_K;
        y_ld = '0;
        z_ld = z_in;
      end
    end
  end

  // one micro-rotation per cycle
  always_comb begin
    sx = x_r >>> cnt_r;
    sy = y_r >>> cnt_r;
    at = ftpg_pkg::atan_entry(5'(cnt_r));
    cw = mode_r ? (y_r >= 0) : (z_r < 0);
    if (cw) begin
      x_nxt = x_r + sy;
      y_nxt = y_r - sx;
      z_nxt = z_r + at;
    end else begin
      x_nxt = x_r - sy;
      y_nxt = y_r + sx;
      z_nxt = z_r - at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        x_r    <= x_ld;
        y_r    <= y_ld;
        z_r    <= z_ld;
        mode_r <= ctl.vec_mode;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        x_r <= x_nxt;
        y_r <= y_nxt;
        z_r <= z_nxt;
        if (cnt_r == ftpg_pkg::STEP_W'(ftpg_pkg::CORDIC_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  assign busy  = busy_r;
  assign done  = done_r;
  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule
`default_nettype wire

### sv/follow_target_pose_generator.sv
// Channel  Dir  Handshake          Payload
// in_      in   in_valid/in_stall  kind, pos_x/y/z, quat_x/y/z/w, now_time
// out_     out  out_valid/out_stall goal_x/y/z, heading, orient_z, orient_w
// cfg_     in   cfg_valid/cfg_ready cfg_index (3b), cfg_data (32b)
//
// Wheelchair poses and dropped caregiver poses are taken in the idle state.
// A goal runs through quaternion products, a CORDIC vectoring run for the yaw
// (skipped when the yaw is forced to zero), the squares of the distances, a
// bit-serial square root, a gain product, two CORDIC rotations and the goal
// products; the CORDIC runs share one CORDIC unit, all products one multiplier.
// in_stall is high while a goal is computed and until it moves into the output
// register; a finished goal waits in the output register while the next pose is taken.
// rst_n is synchronous; config registers reset to their defaults.
`default_nettype none
module follow_target_pose_generator (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire                in_kind,
  input  wire signed [31:0]  in_pos_x,
  input  wire signed [31:0]  in_pos_y,
  input  wire signed [31:0]  in_pos_z,
  input  wire signed [15:0]  in_quat_x,
  input  wire signed [15:0]  in_quat_y,
  input  wire signed [15:0]  in_quat_z,
  input  wire signed [15:0]  in_quat_w,
  input  wire        [31:0]  in_now_time,
  output logic               out_valid,
  input  wire                out_stall,
  output logic signed [31:0] out_goal_x,
  output logic signed [31:0] out_goal_y,
  output logic signed [31:0] out_goal_z,
  output logic signed [15:0] out_heading,
  output logic signed [15:0] out_orient_z,
  output logic signed [15:0] out_orient_w,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire        [2:0]   cfg_index,
  input  wire        [31:0]  cfg_data
);

  localparam int PW = ftpg_pkg::CW + 32;

  typedef enum logic [3:0] {
    S_IDLE, S_QMUL, S_ATAN0, S_ATAN, S_DIFF, S_DMUL, S_SQRT,
    S_GMUL, S_TGT, S_SC1, S_SC2, S_PMUL, S_OUT
  } state_t;

  state_t state_r;
  logic [5:0] cnt_r;

  logic        enable_r;
  logic [23:0] desired_r, floor_r, ceiling_r;
  logic [15:0] gain_r;
  logic [31:0] interval_r;

  logic signed [31:0] chair_x_r, chair_y_r;
  logic               chair_valid_r;
  logic [31:0]        last_time_r;

  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [15:0] qx_r, qy_r, qz_r, qw_r;
  logic signed [31:0] acc_a_r, acc_b_r, acc_c_r, acc_d_r;
  logic signed [PW-1:0] prod_r;
  logic signed [15:0] head_r;
  logic [30:0] ax_r, ay_r;
  logic        sc_r;
  logic [63:0] sq_n_r, sq_root_r, sq_bit_r;
  logic [23:0] tgt_r;
  ftpg_pkg::cval_t cy_r, sy_r;
  logic signed [31:0] gx_r, gy_r;
  logic signed [15:0] oz_r, ow_r;

  logic signed [31:0] o_gx_r, o_gy_r, o_gz_r;
  logic signed [15:0] o_head_r, o_oz_r, o_ow_r;
  logic               out_valid_r;

  ftpg_pkg::cval_t     mul_a;
  logic signed [31:0]  mul_b;
  ftpg_pkg::cordic_ctl_t cctl;
  ftpg_pkg::cval_t     c_x_in, c_y_in, c_z_in, c_x_out, c_y_out, c_z_out;
  logic                c_busy, c_done;

  logic        in_fire, out_free, go;
  logic [31:0] elapsed;
  logic [2:0]  qidx_prev;
  logic signed [31:0] qprod;
  logic signed [32:0] a2, c2, cabs, dx, dy, adx, ady;
  logic        big;
  logic [63:0] sq_t;
  logic        sq_ge;
  logic [32:0] dist_len;
  ftpg_pkg::cval_t err, zs, vs_s, vs_c;
  logic signed [PW-1:0] gsum, rsum;
  logic signed [39:0] tgt_full;
  logic signed [ftpg_pkg::CW-1:0] goal_d;

  function automatic logic signed [31:0] sat32(input logic signed [ftpg_pkg::CW-1:0] v);
    if (v > 34'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] q30_to_q14(input logic signed [ftpg_pkg::CW-1:0] v);
    logic signed [ftpg_pkg::CW-1:0] s;
    logic signed [17:0] q;
    s = v + 34'sd32768;
    q = s[33:16];
    if (q > 18'sd16384) return 16'sd16384;
    if (q < -18'sd16384) return -16'sd16384;
    return q[15:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;
  assign elapsed   = in_now_time - last_time_r;
  assign go        = in_kind && enable_r && chair_valid_r && (elapsed >= interval_r);

  always_comb begin
    qidx_prev = 3'(cnt_r - 6'd1);
    qprod     = prod_r[31:0];
    a2        = {acc_a_r, 1'b0};
    c2        = {acc_c_r, 1'b0};
    cabs      = (c2 < 0) ? -c2 : c2;
    dx        = 33'(px_r) - 33'(chair_x_r);
    dy        = 33'(py_r) - 33'(chair_y_r);
    adx       = (dx < 0) ? -dx : dx;
    ady       = (dy < 0) ? -dy : dy;
    big       = adx[32] || adx[31] || ady[32] || ady[31];
    sq_t      = sq_root_r + sq_bit_r;
    sq_ge     = (sq_n_r >= sq_t);
    dist_len  = sc_r ? {sq_root_r[31:0], 1'b0} : {1'b0, sq_root_r[31:0]};
    err       = ftpg_pkg::cval_t'({1'b0, dist_len}) - ftpg_pkg::cval_t'({10'd0, desired_r});
    gsum      = prod_r + PW'(8192);
    tgt_full  = 40'({16'd0, desired_r}) - gsum[53:14];
    rsum      = prod_r + PW'(536870912);
    zs        = c_z_out + 34'sd32768;
    vs_s      = c_y_out;
    vs_c      = c_x_out;
    goal_d    = '0;
    if (cnt_r == 6'd1) goal_d = ftpg_pkg::cval_t'(px_r) - rsum[63:30];
    else goal_d = ftpg_pkg::cval_t'(py_r) - rsum[63:30];
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_QMUL: begin
        case (cnt_r[2:0])
          3'd0: begin mul_a = ftpg_pkg::cval_t'(qx_r); mul_b = 32'(qx_r); end
          3'd1: begin mul_a = ftpg_pkg::cval_t'(qy_r); mul_b = 32'(qy_r); end
          3'd2: begin mul_a = ftpg_pkg::cval_t'(qz_r); mul_b = 32'(qz_r); end
          3'd3: begin mul_a = ftpg_pkg::cval_t'(qw_r); mul_b = 32'(qw_r); end
          3'd4: begin mul_a = ftpg_pkg::cval_t'(qx_r); mul_b = 32'(qy_r); end
          3'd5: begin mul_a = ftpg_pkg::cval_t'(qw_r); mul_b = 32'(qz_r); end
          3'd6: begin mul_a = ftpg_pkg::cval_t'(qx_r); mul_b = 32'(qz_r); end
          default: begin mul_a = ftpg_pkg::cval_t'(qw_r); mul_b = 32'(qy_r); end
        endcase
      end
      S_DMUL: begin
        if (cnt_r == 6'd0) begin
          mul_a = ftpg_pkg::cval_t'({3'd0, ax_r});
          mul_b = {1'b0, ax_r};
        end else begin
          mul_a = ftpg_pkg::cval_t'({3'd0, ay_r});
          mul_b = {1'b0, ay_r};
        end
      end
      S_GMUL: begin
        mul_a = err;
        mul_b = {16'd0, gain_r};
      end
      S_PMUL: begin
        mul_a = (cnt_r == 6'd0) ? cy_r : sy_r;
        mul_b = {8'd0, tgt_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // CORDIC launch
  always_comb begin
    cctl.start    = 1'b0;
    cctl.vec_mode = 1'b0;
    c_x_in = ftpg_pkg::cval_t'(acc_b_r);
    c_y_in = ftpg_pkg::cval_t'(a2);
    c_z_in = '0;
    unique case (state_r)
      S_ATAN0: begin
        cctl.start    = (cabs < {1'b0, acc_d_r});
        cctl.vec_mode = 1'b1;
      end
      S_TGT: begin
        cctl.start = 1'b1;
        c_z_in = ftpg_pkg::cval_t'(head_r) <<< 16;
      end
      S_SC1: begin
        cctl.start = c_done;
        c_z_in = ftpg_pkg::cval_t'(head_r) <<< 15;
      end
      default: cctl.start = 1'b0;
    endcase
  end

  ftpg_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cctl),
    .x_in  (c_x_in),
    .y_in  (c_y_in),
    .z_in  (c_z_in),
    .busy  (c_busy),
    .done  (c_done),
    .x_out (c_x_out),
    .y_out (c_y_out),
    .z_out (c_z_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      enable_r      <= 1'b0;
      desired_r     <= 24'd85197;
      floor_r       <= 24'd32768;
      ceiling_r     <= 24'd131072;
      gain_r        <= 16'd9830;
      interval_r    <= 32'd50000;
      chair_x_r     <= '0;
      chair_y_r     <= '0;
      chair_valid_r <= 1'b0;
      last_time_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      prod_r <= mul_a * mul_b;

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ftpg_pkg::REG_FOLLOW_ENABLE:    enable_r   <= cfg_data[0];
          ftpg_pkg::REG_DESIRED_DISTANCE: desired_r  <= cfg_data[23:0];
          ftpg_pkg::REG_OFFSET_FLOOR:     floor_r    <= cfg_data[23:0];
          ftpg_pkg::REG_OFFSET_CEILING:   ceiling_r  <= cfg_data[23:0];
          ftpg_pkg::REG_DISTANCE_GAIN:    gain_r     <= cfg_data[15:0];
          ftpg_pkg::REG_MIN_INTERVAL:     interval_r <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && state_r != S_OUT) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (!in_kind) begin
              chair_x_r     <= in_pos_x;
              chair_y_r     <= in_pos_y;
              chair_valid_r <= 1'b1;
            end else if (go) begin
              px_r <= in_pos_x;
              py_r <= in_pos_y;
              pz_r <= in_pos_z;
              qx_r <= in_quat_x;
              qy_r <= in_quat_y;
              qz_r <= in_quat_z;
              qw_r <= in_quat_w;
              last_time_r <= in_now_time;
              acc_a_r <= '0;
              acc_b_r <= '0;
              acc_c_r <= '0;
              acc_d_r <= '0;
              cnt_r   <= '0;
              state_r <= S_QMUL;
            end
          end
        end
        S_QMUL: begin
          // accumulate the product issued last cycle
          if (cnt_r != 6'd0) begin
            case (qidx_prev)
              3'd0, 3'd3: begin
                acc_b_r <= acc_b_r + qprod;
                acc_d_r <= acc_d_r + qprod;
              end
              3'd1, 3'd2: begin
                acc_b_r <= acc_b_r - qprod;
                acc_d_r <= acc_d_r + qprod;
              end
              3'd4, 3'd5: acc_a_r <= acc_a_r + qprod;
              3'd6:       acc_c_r <= acc_c_r + qprod;
              default:    acc_c_r <= acc_c_r - qprod;
            endcase
          end
          if (cnt_r == 6'd8) state_r <= S_ATAN0;
          else cnt_r <= cnt_r + 6'd1;
        end
        S_ATAN0: begin
          if (cctl.start) begin
            state_r <= S_ATAN;
          end else begin
            // gimbal lock or zero quaternion
            head_r  <= '0;
            state_r <= S_DIFF;
          end
        end
        S_ATAN: begin
          if (c_done) begin
            head_r  <= zs[31:16];
            state_r <= S_DIFF;
          end
        end
        S_DIFF: begin
          ax_r    <= big ? adx[31:1] : adx[30:0];
          ay_r    <= big ? ady[31:1] : ady[30:0];
          sc_r    <= big;
          cnt_r   <= '0;
          state_r <= S_DMUL;
        end
        S_DMUL: begin
          if (cnt_r == 6'd1) sq_n_r <= prod_r[63:0];
          if (cnt_r == 6'd2) begin
            sq_n_r    <= sq_n_r + prod_r[63:0];
            sq_root_r <= '0;
            sq_bit_r  <= 64'h4000000000000000;
            cnt_r     <= '0;
            state_r   <= S_SQRT;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_SQRT: begin
          if (sq_ge) begin
            sq_n_r    <= sq_n_r - sq_t;
            sq_root_r <= (sq_root_r >> 1) + sq_bit_r;
          end else begin
            sq_root_r <= sq_root_r >> 1;
          end
          sq_bit_r <= sq_bit_r >> 2;
          if (cnt_r == 6'd31) state_r <= S_GMUL;
          else cnt_r <= cnt_r + 6'd1;
        end
        S_GMUL: state_r <= S_TGT;
        S_TGT: begin
          // ceiling applied last so it wins when the limits cross
          if (tgt_full < $signed({16'd0, floor_r}))
            tgt_r <= (floor_r > ceiling_r) ? ceiling_r : floor_r;
          else if (tgt_full > $signed({16'd0, ceiling_r})) tgt_r <= ceiling_r;
          else tgt_r <= tgt_full[23:0];
          state_r <= S_SC1;
        end
        S_SC1: begin
          if (c_done) begin
            cy_r    <= c_x_out;
            sy_r    <= c_y_out;
            state_r <= S_SC2;
          end
        end
        S_SC2: begin
          if (c_done) begin
            oz_r    <= q30_to_q14(vs_s);
            ow_r    <= q30_to_q14(vs_c);
            cnt_r   <= '0;
            state_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          if (cnt_r == 6'd1) gx_r <= sat32(goal_d);
          if (cnt_r == 6'd2) begin
            gy_r    <= sat32(goal_d);
            state_r <= S_OUT;
          end else begin
            cnt_r <= cnt_r + 6'd1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            o_gx_r      <= gx_r;
            o_gy_r      <= gy_r;
            o_gz_r      <= pz_r;
            o_head_r    <= head_r;
            o_oz_r      <= oz_r;
            o_ow_r      <= ow_r;
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = out_valid_r;
  assign out_goal_x   = o_gx_r;
  assign out_goal_y   = o_gy_r;
  assign out_goal_z   = o_gz_r;
  assign out_heading  = o_head_r;
  assign out_orient_z = o_oz_r;
  assign out_orient_w = o_ow_r;

  a_cordic_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cctl.start |-> !c_busy) else $error("CORDIC restarted while busy");

  a_idle_cordic: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !c_busy) else $error("CORDIC busy while idle");

  a_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
    c_done |-> (state_r == S_ATAN || state_r == S_SC1 || state_r == S_SC2))
    else $error("CORDIC result with no waiting state");

  a_goal_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_free) |=> out_valid_r)
    else $error("goal not presented");

endmodule
`default_nettype wire

### sim/follow_target_pose_generator_test.sv
`timescale 1ns / 100ps
`default_nettype none
module follow_target_pose_generator_test;

  localparam int STEPS = ftpg_pkg::CORDIC_STEPS > 31 ? 31 : ftpg_pkg::CORDIC_STEPS;
  localparam longint QUARTER = 64'sd1073741824;
  localparam longint KGAIN = 64'sd652032874;
  localparam longint CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic signed [31:0] goal_z;
    logic signed [15:0] heading;
    logic signed [15:0] orient_z;
    logic signed [15:0] orient_w;
  } goal_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  wire in_stall;
  logic in_kind = 0;
  logic signed [31:0] in_pos_x = 0, in_pos_y = 0, in_pos_z = 0;
  logic signed [15:0] in_quat_x = 0, in_quat_y = 0, in_quat_z = 0, in_quat_w = 0;
  logic [31:0] in_now_time = 0;
  wire out_valid;
  logic out_stall = 0;
  wire signed [31:0] out_goal_x, out_goal_y, out_goal_z;
  wire signed [15:0] out_heading, out_orient_z, out_orient_w;
  logic cfg_valid = 0;
  wire cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;

  follow_target_pose_generator uut (.*);

  always #5 clk = ~clk;

  // predictor state
  logic enable_q;
  logic [23:0] desired_q, floor_q, ceiling_q;
  logic [15:0] gain_q;
  logic [31:0] interval_q;
  longint chair_x_q, chair_y_q;
  logic chair_seen;
  logic [31:0] last_goal_q;

  goal_t expected_goals[$];
  int errors = 0;
  int goals_seen = 0;
  int poses_sent = 0;
  longint cycles = 0;
  bit hold_off = 0;
  bit rx_random = 1;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint atan_val(int i);
    return longint'(ftpg_pkg::atan_entry(i[4:0]));
  endfunction

  function automatic longint yaw_from_vector(longint a, longint b);
    longint x = b, y = a, z = 0, nx;
    if (b < 0) begin
      if (a >= 0) begin
        x = a; y = -b; z = QUARTER;
      end else begin
        x = -a; y = b; z = -QUARTER;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + asr(y, i); y = y - asr(x, i); z += atan_val(i);
      end else begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= atan_val(i);
      end
      x = nx;
    end
    return z;
  endfunction

  task automatic rotate(input longint ang, output longint c, output longint s);
    longint x = KGAIN, y = 0, z = ang, nx;
    if (z > QUARTER) begin
      x = 0; y = KGAIN; z -= QUARTER;
    end else if (z < -QUARTER) begin
      x = 0; y = -KGAIN; z += QUARTER;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= atan_val(i);
      end else begin
        nx = x + asr(y, i); y = y - asr(x, i); z += atan_val(i);
      end
      x = nx;
    end
    c = x;
    s = y;
  endtask

  function automatic longint root_of(longint unsigned n);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return longint'(r);
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint to_q14(longint v);
    v = asr(v + 32768, 16);
    if (v > 16384) v = 16384;
    if (v < -16384) v = -16384;
    return v;
  endfunction

  task automatic set_defaults();
    enable_q = 0; desired_q = 85197; floor_q = 32768; ceiling_q = 131072;
    gain_q = 9830; interval_q = 50000;
    chair_x_q = 0; chair_y_q = 0; chair_seen = 0; last_goal_q = 0;
  endtask

  task automatic predict_pose(input logic kind, input longint px, input longint py,
                              input longint pz, input longint qx, input longint qy,
                              input longint qz, input longint qw, input logic [31:0] now);
    longint a, b, c, d, h, dx, dy, dist_v, tgt, cy, sy, ch, sh;
    longint unsigned ax, ay;
    int sc;
    logic [31:0] elapsed;
    goal_t g;
    sc = 0;
    if (!kind) begin
      chair_x_q = px; chair_y_q = py; chair_seen = 1;
      return;
    end
    elapsed = now - last_goal_q;
    if (!enable_q || !chair_seen || elapsed < interval_q) return;
    a = 2 * (qx * qy + qw * qz);
    b = qx * qx + qw * qw - qy * qy - qz * qz;
    c = 2 * (qx * qz - qw * qy);
    d = qx * qx + qy * qy + qz * qz + qw * qw;
    if (c < 0) c = -c;
    if (c >= d) h = 0;
    else begin
      h = asr(yaw_from_vector(a, b) + 32768, 16);
      if (h > 32767) h -= 65536;
      if (h < -32768) h += 65536;
    end
    dx = px - chair_x_q;
    dy = py - chair_y_q;
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    if (ax >= 64'h80000000 || ay >= 64'h80000000) begin
      ax >>= 1; ay >>= 1; sc = 1;
    end
    dist_v = root_of(ax * ax + ay * ay) << sc;
    tgt = longint'(desired_q)
        - asr(longint'(gain_q) * (dist_v - longint'(desired_q)) + 8192, 14);
    if (tgt < longint'(floor_q)) tgt = longint'(floor_q);
    if (tgt > longint'(ceiling_q)) tgt = longint'(ceiling_q);
    rotate(h * 65536, cy, sy);
    rotate(h * 32768, ch, sh);
    g.goal_x = 32'(clip32(px - asr(tgt * cy + (64'sd1 << 29), 30)));
    g.goal_y = 32'(clip32(py - asr(tgt * sy + (64'sd1 << 29), 30)));
    g.goal_z = 32'(pz);
    g.heading = 16'(h);
    g.orient_z = 16'(to_q14(sh));
    g.orient_w = 16'(to_q14(ch));
    expected_goals.push_back(g);
    last_goal_q = now;
  endtask

  // in_valid is held low during each write, and cfg_valid is dropped before the task returns
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    in_valid <= 0;
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      ftpg_pkg::REG_FOLLOW_ENABLE:    enable_q = val[0];
      ftpg_pkg::REG_DESIRED_DISTANCE: desired_q = val[23:0];
      ftpg_pkg::REG_OFFSET_FLOOR:     floor_q = val[23:0];
      ftpg_pkg::REG_OFFSET_CEILING:   ceiling_q = val[23:0];
      ftpg_pkg::REG_DISTANCE_GAIN:    gain_q = val[15:0];
      ftpg_pkg::REG_MIN_INTERVAL:     interval_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // valid stays high after a transaction; a gap in the next call, a register write or an idle point drops it
  task automatic send_pose(input logic kind, input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [15:0] qx,
                           input logic [15:0] qy, input logic [15:0] qz,
                           input logic [15:0] qw, input logic [31:0] now,
                           input bit gaps = 1);
    int gap;
    gap = gaps ? $urandom_range(0, 15) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_kind <= kind;
    in_pos_x <= px; in_pos_y <= py; in_pos_z <= pz;
    in_quat_x <= qx; in_quat_y <= qy; in_quat_z <= qz; in_quat_w <= qw;
    in_now_time <= now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pose(kind, $signed(px), $signed(py), $signed(pz), $signed(qx),
                 $signed(qy), $signed(qz), $signed(qw), now);
    poses_sent++;
  endtask

  // idle point: all goals delivered plus margin for a pose still in flight
  task automatic drain();
    in_valid <= 0;
    while (expected_goals.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_quat();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic random_caregiver(input logic [31:0] now, input bit gaps = 1);
    send_pose(1, $urandom, $urandom, $urandom, rand_quat(), rand_quat(),
              rand_quat(), rand_quat(), now, gaps);
  endtask

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n) begin
      if (rx_random) out_stall <= hold_off || ($urandom_range(0, 3) == 0);
      else out_stall <= hold_off;
      if (out_valid && !out_stall) begin
        goals_seen++;
        if (expected_goals.size() == 0) begin
          $display("%0t: unexpected goal x=%0d y=%0d", $time, out_goal_x, out_goal_y);
          errors++;
        end else begin
          goal_t e;
          e = expected_goals.pop_front();
          if (out_goal_x !== e.goal_x) begin
            $display("%0t: goal_x expected %0d actual %0d", $time, e.goal_x, out_goal_x);
            errors++;
          end
          if (out_goal_y !== e.goal_y) begin
            $display("%0t: goal_y expected %0d actual %0d", $time, e.goal_y, out_goal_y);
            errors++;
          end
          if (out_goal_z !== e.goal_z) begin
            $display("%0t: goal_z expected %0d actual %0d", $time, e.goal_z, out_goal_z);
            errors++;
          end
          if (out_heading !== e.heading) begin
            $display("%0t: heading expected %0d actual %0d", $time, e.heading,
                     out_heading);
            errors++;
          end
          if (out_orient_z !== e.orient_z) begin
            $display("%0t: orient_z expected %0d actual %0d", $time, e.orient_z,
                     out_orient_z);
            errors++;
          end
          if (out_orient_w !== e.orient_w) begin
            $display("%0t: orient_w expected %0d actual %0d", $time, e.orient_w,
                     out_orient_w);
            errors++;
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic test_gating();
    // enable off, no chair, interval not elapsed: those drop; the others make goals
    send_pose(1, 0, 0, 0, 0, 0, 0, 16384, 32'hFFFF_FFFF);
    write_reg(ftpg_pkg::REG_FOLLOW_ENABLE, 1);
    send_pose(1, 0, 0, 0, 0, 0, 0, 16384, 32'hFFFF_FFFF);
    send_pose(0, 32'h0001_0000, 0, 7, 1, 2, 3, 4, 0);
    send_pose(1, 0, 0, 5, 0, 0, 0, 16384, 49999);
    send_pose(1, 0, 0, 5, 0, 0, 0, 16384, 50000);
    send_pose(1, 0, 0, 5, 0, 0, 0, 16384, 60000);
    send_pose(1, 0, 0, 5, 0, 0, 0, 16384, 100000);
    // wrapping elapsed time
    send_pose(1, 0, 0, 5, 0, 0, 0, 16384, 32'hFFFF_FFFF);
    send_pose(1, 0, 0, 5, 0, 0, 0, 16384, 30000);
    send_pose(1, 0, 0, 5, 0, 0, 0, 16384, 49999);
    drain();
  endtask

  task automatic test_directed_extremes();
    logic [15:0] q [6][4];
    q = '{'{0, 0, 0, 0}, '{16384, 0, 0, 0}, '{0, 0, 16384, 0},
          '{0, 0, 16384, -16384}, '{-16384, -16384, -16384, -16384},
          '{0, 16384, 0, 16384}};
    write_reg(ftpg_pkg::REG_MIN_INTERVAL, 0);
    send_pose(0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
    send_pose(1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 16384, 1);
    send_pose(1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 16384, 0, 2);
    for (int i = 0; i < 6; i++)
      send_pose(1, 32'h0002_0000, 32'hFFFF_0000, i, q[i][0], q[i][1], q[i][2], q[i][3],
                3 + i);
    send_pose(0, 0, 0, 0, 16384, -16384, 16384, -16384, 32'hFFFF_FFFF);
    send_pose(1, 32'h0000_8000, 0, 0, 0, 0, -16384, 16384, 20);
    drain();
  endtask

  task automatic random_phase(input int n, input int chair_pct);
    logic [31:0] now;
    now = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < chair_pct) begin
        if ($urandom_range(0, 1))
          send_pose(0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom);
        else
          send_pose(0, $signed($urandom_range(0, 2000000)) - 1000000,
                    $signed($urandom_range(0, 2000000)) - 1000000, 0, 0, 0, 0, 0, 0);
      end else begin
        now = now + $urandom_range(0, 3) * (interval_q >> 1) + $urandom_range(0, 100);
        if ($urandom_range(0, 2) == 0) random_caregiver($urandom);
        else send_pose(1, $signed($urandom_range(0, 2000000)) - 1000000,
                       $signed($urandom_range(0, 2000000)) - 1000000, $urandom,
                       rand_quat(), rand_quat(), rand_quat(), rand_quat(), now);
      end
    end
    drain();
  endtask

  task automatic test_random_settings();
    write_reg(ftpg_pkg::REG_FOLLOW_ENABLE, 1);
    write_reg(ftpg_pkg::REG_MIN_INTERVAL, 1000);
    random_phase(150, 25);
    // extremes: floor above ceiling, max gain, max distances
    write_reg(ftpg_pkg::REG_DESIRED_DISTANCE, 24'hFFFFFF);
    write_reg(ftpg_pkg::REG_OFFSET_FLOOR, 24'hFFFFFF);
    write_reg(ftpg_pkg::REG_OFFSET_CEILING, 24'h000100);
    write_reg(ftpg_pkg::REG_DISTANCE_GAIN, 16'hFFFF);
    write_reg(ftpg_pkg::REG_MIN_INTERVAL, 0);
    random_phase(80, 20);
    write_reg(ftpg_pkg::REG_DESIRED_DISTANCE, 0);
    write_reg(ftpg_pkg::REG_OFFSET_FLOOR, 0);
    write_reg(ftpg_pkg::REG_OFFSET_CEILING, 24'hFFFFFF);
    write_reg(ftpg_pkg::REG_DISTANCE_GAIN, 0);
    random_phase(60, 20);
    write_reg(ftpg_pkg::REG_DESIRED_DISTANCE, $urandom);
    write_reg(ftpg_pkg::REG_OFFSET_FLOOR, $urandom_range(0, 200000));
    write_reg(ftpg_pkg::REG_OFFSET_CEILING, $urandom);
    write_reg(ftpg_pkg::REG_DISTANCE_GAIN, $urandom);
    write_reg(ftpg_pkg::REG_MIN_INTERVAL, 32'hFFFF_FFFF);
    random_phase(30, 30);
    write_reg(ftpg_pkg::REG_MIN_INTERVAL, 500);
    random_phase(100, 20);
  endtask

  task automatic test_backpressure();
    // receiver holds off while sender keeps offering
    write_reg(ftpg_pkg::REG_MIN_INTERVAL, 0);
    hold_off = 1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) random_caregiver(i, 0);
    join
    drain();
    // sender waits for every goal before each pose, receiver never stalls
    rx_random = 0;
    for (int i = 0; i < 10; i++) begin
      random_caregiver(i, 0);
      in_valid <= 0;
      while (expected_goals.size() != 0) @(posedge clk);
    end
    rx_random = 1;
    drain();
  endtask

  initial begin
    set_defaults();
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_gating();
    test_directed_extremes();
    test_random_settings();
    test_backpressure();
    write_reg(ftpg_pkg::REG_FOLLOW_ENABLE, 0);
    random_phase(20, 30);
    $display("%0d poses sent, %0d goals checked over gating, extreme settings,",
             poses_sent, goals_seen);
    $display("random poses and output backpressure");
    if (errors == 0 && expected_goals.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
